FILE: hw/rtl/escaped_length_frame_splitter_core_defines.svh
// Assertion macros for the escaped-length frame splitter checker.
`ifndef ESCAPED_LENGTH_FRAME_SPLITTER_CORE_DEFINES_SVH
`define ESCAPED_LENGTH_FRAME_SPLITTER_CORE_DEFINES_SVH

// Checked on every rising clock edge outside reset.
`define ELFS_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ELFS_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/elfs_pkg.sv
// Shared types and constants of the escaped-length frame splitter.
package elfs_pkg;

	localparam int BYTE_W = 8;
	localparam int LEN_W = 16;
	localparam int MAX_PAYLOAD_DEF = 1024;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	localparam logic [BYTE_W-1:0] ESC_XOR = 8'h20;
	localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'd126;
	localparam logic [BYTE_W-1:0] ESCAPE_BYTE_RST = 8'd125;

	localparam logic REG_START_BYTE = 1'b0;
	localparam logic REG_ESCAPE_BYTE = 1'b1;

	typedef struct packed {
		logic [BYTE_W-1:0] start_byte;
		logic [BYTE_W-1:0] escape_byte;
	} cfg_t;

	typedef struct packed {
		logic              len_too_long;
		logic [LEN_W-1:0]  payload_length;
		logic              length_done;
		logic              frame_last;
		logic              frame_first;
		logic [BYTE_W-1:0] frame_byte;
	} res_t;

endpackage

FILE: hw/rtl/elfs_cfg.sv
// Configuration register file of the frame splitter, written over the APB port.
module elfs_cfg import elfs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t cfg_q;
	logic wr_en;
	logic reg_sel;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;
	assign reg_sel = paddr[2];
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte <= START_BYTE_RST;
			cfg_q.escape_byte <= ESCAPE_BYTE_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_START_BYTE: cfg_q.start_byte <= pwdata[BYTE_W-1:0];
				REG_ESCAPE_BYTE: cfg_q.escape_byte <= pwdata[BYTE_W-1:0];
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			REG_START_BYTE: prdata[BYTE_W-1:0] = cfg_q.start_byte;
			REG_ESCAPE_BYTE: prdata[BYTE_W-1:0] = cfg_q.escape_byte;
		endcase
	end

endmodule

FILE: hw/rtl/elfs_in_stage.sv
// Input register stage that holds one received byte for the parser.
module elfs_in_stage import elfs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BYTE_W-1:0] in_byte,
	output logic              valid_s1,
	output logic [BYTE_W-1:0] byte_s1,
	input  logic              take
);

	logic valid_q;

	assign in_ready = !valid_q || take;
	assign valid_s1 = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

endmodule

FILE: hw/rtl/elfs_parser.sv
// Frame parser state machine with its result register.
module elfs_parser import elfs_pkg::*; #(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              valid_s1,
	input  logic [BYTE_W-1:0] byte_s1,
	output logic              take,
	output logic              out_valid,
	input  logic              out_ready,
	output res_t              res
);

	localparam int CntW = $clog2(MAX_PAYLOAD + 2);

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_LEN_HI,
		PH_LEN_LO,
		PH_PAYLOAD
	} phase_t;

	phase_t            phase_q, phase_d;
	logic              esc_q, esc_d;
	logic [BYTE_W-1:0] len_hi_q, len_hi_d;
	logic [CntW-1:0]   left_q, left_d;
	logic              out_valid_q;
	res_t              res_q;
	res_t              res_c;
	logic              emit_c;
	logic              out_free;
	logic [BYTE_W-1:0] byte_x;
	logic [LEN_W-1:0]  len_c;

	assign byte_x = esc_q ? (byte_s1 ^ ESC_XOR) : byte_s1;
	assign len_c = {len_hi_q, byte_x};
	assign out_free = !out_valid_q || out_ready;
	assign take = valid_s1 && (out_free || !emit_c);
	assign out_valid = out_valid_q;
	assign res = res_q;

	always_comb begin
		phase_d = phase_q;
		esc_d = esc_q;
		len_hi_d = len_hi_q;
		left_d = left_q;
		emit_c = 1'b0;
		res_c = '0;
		res_c.frame_byte = byte_s1;
		unique case (phase_q)
			PH_PAYLOAD: begin
				emit_c = 1'b1;
				if (left_q <= CntW'(1)) begin
					res_c.frame_last = 1'b1;
					left_d = '0;
					phase_d = PH_HUNT;
				end else begin
					left_d = left_q - CntW'(1);
				end
			end
			default: begin
				priority if (byte_s1 == cfg.start_byte) begin
					emit_c = 1'b1;
					res_c.frame_first = 1'b1;
					phase_d = PH_LEN_HI;
					esc_d = 1'b0;
					len_hi_d = '0;
				end else if (phase_q == PH_HUNT) begin
					emit_c = 1'b0;
				end else if (!esc_q && byte_s1 == cfg.escape_byte) begin
					emit_c = 1'b1;
					esc_d = 1'b1;
				end else if (phase_q == PH_LEN_HI) begin
					emit_c = 1'b1;
					res_c.frame_byte = byte_x;
					esc_d = 1'b0;
					len_hi_d = byte_x;
					phase_d = PH_LEN_LO;
				end else begin
					emit_c = 1'b1;
					esc_d = 1'b0;
					res_c.frame_byte = byte_x;
					res_c.length_done = 1'b1;
					res_c.payload_length = len_c;
					if (len_c > LEN_W'(MAX_PAYLOAD)) begin
						res_c.len_too_long = 1'b1;
						res_c.frame_last = 1'b1;
						left_d = '0;
						phase_d = PH_HUNT;
					end else begin
						left_d = CntW'(len_c) + CntW'(1);
						phase_d = PH_PAYLOAD;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			esc_q <= 1'b0;
			len_hi_q <= '0;
			left_q <= '0;
			out_valid_q <= 1'b0;
			res_q <= '0;
		end else begin
			if (take) begin
				phase_q <= phase_d;
				esc_q <= esc_d;
				len_hi_q <= len_hi_d;
				left_q <= left_d;
			end
			if (out_free) begin
				out_valid_q <= take && emit_c;
				if (take && emit_c) begin
					res_q <= res_c;
				end
			end
		end
	end

endmodule

FILE: hw/rtl/escaped_length_frame_splitter_core.sv
// Top level of the escaped-length frame splitter.
// The slave stream takes one received byte per item in s_axis_tdata. The block hunts
// for the start byte, decodes a 16-bit big-endian length whose bytes may each be
// preceded by the escape byte, then passes length+1 payload and checksum bytes.
// Every byte kept in a frame leaves on the master stream as one item; bytes seen
// while hunting give no item. tuser marks the start byte, the end of the length
// header and an oversized length; tlast marks the checksum byte or a rejected
// length byte. The start and escape bytes are set over the APB port.
// An accepted item is held in the input register; when the parser takes it, its next
// state is loaded, and the result register too if the byte yields an item. One item
// per cycle is sustained while the receiver does not stall; the parser's state update
// is the only loop.
// Reset clears the pending item and result, returns the parser to hunting and loads
// 126 as start byte and 125 as escape byte.
// While the receiver stalls, the result register holds its item, the input register
// keeps one more byte, and s_axis_tready then falls until the result is taken.
module escaped_length_frame_splitter_core import elfs_pkg::*; #(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [7:0]            s_axis_tdata,  // rx_byte
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [23:0]           m_axis_tdata,  // frame_byte, payload_length
	output logic                  m_axis_tlast,  // frame_last
	output logic [2:0]            m_axis_tuser   // frame_first, length_done, len_too_long
);

	cfg_t              cfg;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              take;
	res_t              res;

	elfs_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	elfs_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.take     (take)
	);

	elfs_parser #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.valid_s1  (valid_s1),
		.byte_s1   (byte_s1),
		.take      (take),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.res       (res)
	);

	assign m_axis_tdata = {res.payload_length, res.frame_byte};
	assign m_axis_tlast = res.frame_last;
	assign m_axis_tuser = {res.len_too_long, res.length_done, res.frame_first};

endmodule

FILE: hw/rtl/elfs_checker.sv
// Port-level checker for the frame splitter and its bind to the top level.
`include "escaped_length_frame_splitter_core_defines.svh"

module elfs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic        m_axis_tlast,
	input logic [2:0]  m_axis_tuser
);

	`ELFS_ASSERT_ALWAYS(a_no_item_in_reset, !arst_n |-> !m_axis_tvalid, "item shown during reset")
	`ELFS_ASSERT(a_stall_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled item changed")
	`ELFS_ASSERT(a_err_ends_header, m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1] && m_axis_tlast, "length error without header end and frame end")
	`ELFS_ASSERT(a_len_only_on_done, m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[23:8] == 16'd0, "length shown outside header end")
	`ELFS_ASSERT(a_first_alone, m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tlast && !m_axis_tuser[1], "start byte flagged as header end or frame end")

endmodule

bind escaped_length_frame_splitter_core elfs_checker u_elfs_checker (.*);

FILE: test/tb_escaped_length_frame_splitter_core.sv
// Self-checking testbench of the escaped-length frame splitter core.
`timescale 1ns / 100ps

module tb_escaped_length_frame_splitter_core;
	import elfs_pkg::*;

	localparam int MAX_LEN = MAX_PAYLOAD_DEF;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT = 600000;
	localparam int LONG_HOLD_CYCLES = 200;

	typedef enum logic [1:0] {
		SEEK_START,
		WANT_LEN_HI,
		WANT_LEN_LO,
		IN_PAYLOAD
	} split_phase_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b1;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata = '0;  // rx_byte
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [23:0]           m_axis_tdata;       // frame_byte, payload_length
	logic                  m_axis_tlast;       // frame_last
	logic [2:0]            m_axis_tuser;       // frame_first, length_done, len_too_long

	escaped_length_frame_splitter_core #(
		.MAX_PAYLOAD(MAX_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser)
	);

	logic [7:0] rx_queue[$];
	res_t frame_expect_q[$];

	split_phase_t split_phase = SEEK_START;
	logic         esc_armed = 1'b0;
	logic [7:0]   len_hi_byte = '0;
	logic [16:0]  bytes_to_pass = '0;
	logic [7:0]   cur_start = START_BYTE_RST;
	logic [7:0]   cur_escape = ESCAPE_BYTE_RST;

	int src_idle_pct = 0;
	int sink_idle_pct = 0;
	int frame_items_fed = 0;
	int items_accepted = 0;
	int results_checked = 0;
	int frames_closed = 0;
	int length_rejects = 0;
	int mismatches = 0;
	int cycle_count = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	// Mostly zero, sometimes a short gap, rarely a long one.
	function automatic int pick_gap(input int idle_pct);
		if ($urandom_range(0, 99) >= idle_pct)
			return 0;
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	// Advances the deframer state by one received byte and queues the item it yields.
	task automatic deframe_step(input logic [7:0] b);
		res_t r;
		logic [7:0] v;
		logic [16:0] len;
		r = '0;
		r.frame_byte = b;
		if (split_phase == IN_PAYLOAD) begin
			if (bytes_to_pass <= 17'd1) begin
				bytes_to_pass = '0;
				split_phase = SEEK_START;
				r.frame_last = 1'b1;
			end else begin
				bytes_to_pass = bytes_to_pass - 17'd1;
			end
			frame_expect_q.push_back(r);
		end else if (b == cur_start) begin
			split_phase = WANT_LEN_HI;
			esc_armed = 1'b0;
			len_hi_byte = '0;
			r.frame_first = 1'b1;
			frame_expect_q.push_back(r);
		end else if (split_phase == SEEK_START) begin
		end else if (!esc_armed && b == cur_escape) begin
			esc_armed = 1'b1;
			frame_expect_q.push_back(r);
		end else begin
			v = esc_armed ? (b ^ ESC_XOR) : b;
			esc_armed = 1'b0;
			r.frame_byte = v;
			if (split_phase == WANT_LEN_HI) begin
				len_hi_byte = v;
				split_phase = WANT_LEN_LO;
			end else begin
				len = {1'b0, len_hi_byte, v};
				r.length_done = 1'b1;
				r.payload_length = len[15:0];
				if (len > 17'(MAX_LEN)) begin
					r.len_too_long = 1'b1;
					r.frame_last = 1'b1;
					split_phase = SEEK_START;
					bytes_to_pass = '0;
				end else begin
					split_phase = IN_PAYLOAD;
					bytes_to_pass = len + 17'd1;
				end
			end
			frame_expect_q.push_back(r);
		end
	endtask

	always @(posedge clk) begin : rx_driver
		int gap_left;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			gap_left = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				deframe_step(s_axis_tdata);
				items_accepted++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (rx_queue.size() != 0) begin
					s_axis_tdata <= rx_queue.pop_front();
					s_axis_tvalid <= 1'b1;
					gap_left = pick_gap(src_idle_pct);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	task automatic flag_mismatch(input string field, input logic [15:0] want,
			input logic [15:0] got);
		$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
		mismatches++;
	endtask

	always @(posedge clk) begin : frame_monitor
		res_t got;
		res_t want;
		int hold_left;
		int n;
		bit long_hold_done;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_left = 0;
			long_hold_done = 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = '0;
				got.frame_byte = m_axis_tdata[7:0];
				got.payload_length = m_axis_tdata[23:8];
				got.frame_first = m_axis_tuser[0];
				got.length_done = m_axis_tuser[1];
				got.len_too_long = m_axis_tuser[2];
				got.frame_last = m_axis_tlast;
				if (frame_expect_q.size() == 0) begin
					$display("%0t: unexpected item, expected none, actual 0x%0h", $time, got);
					mismatches++;
				end else begin
					want = frame_expect_q.pop_front();
					if (got.frame_byte !== want.frame_byte)
						flag_mismatch("frame_byte", 16'(want.frame_byte),
							16'(got.frame_byte));
					if (got.frame_first !== want.frame_first)
						flag_mismatch("frame_first", 16'(want.frame_first),
							16'(got.frame_first));
					if (got.frame_last !== want.frame_last)
						flag_mismatch("frame_last", 16'(want.frame_last),
							16'(got.frame_last));
					if (got.length_done !== want.length_done)
						flag_mismatch("length_done", 16'(want.length_done),
							16'(got.length_done));
					if (got.payload_length !== want.payload_length)
						flag_mismatch("payload_length", want.payload_length,
							got.payload_length);
					if (got.len_too_long !== want.len_too_long)
						flag_mismatch("len_too_long", 16'(want.len_too_long),
							16'(got.len_too_long));
					results_checked++;
					if (want.frame_last)
						frames_closed++;
					if (want.len_too_long)
						length_rejects++;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (!long_hold_done && results_checked >= 120) begin
				long_hold_done = 1'b1;
				hold_left = LONG_HOLD_CYCLES - 1;
				m_axis_tready <= 1'b0;
			end else begin
				n = pick_gap(sink_idle_pct);
				if (n == 0) begin
					m_axis_tready <= 1'b1;
				end else begin
					hold_left = n - 1;
					m_axis_tready <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			if (frame_expect_q.size() != 0)
				$display("%0d expected items never arrived", frame_expect_q.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic cfg_write(input logic idx, input logic [7:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= APB_DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_START_BYTE)
			cur_start = value;
		else
			cur_escape = value;
	endtask

	task automatic wait_idle();
		while (rx_queue.size() != 0 || s_axis_tvalid || frame_expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic push_rx(input logic [7:0] b, input bit counted);
		rx_queue.push_back(b);
		if (counted)
			frame_items_fed++;
	endtask

	// Length bytes escaped on collision or at random, if start!=escape, v^0x20!=start.
	task automatic push_len_byte(input logic [7:0] v, input int esc_pct);
		logic must_esc;
		must_esc = (v == cur_start) || (v == cur_escape);
		if (cur_start != cur_escape && (v ^ ESC_XOR) != cur_start
				&& (must_esc || $urandom_range(0, 99) < esc_pct)) begin
			push_rx(cur_escape, 1'b1);
			push_rx(v ^ ESC_XOR, 1'b1);
		end else begin
			push_rx(v, 1'b1);
		end
	endtask

	task automatic push_frame(input int len, input int esc_pct);
		logic [15:0] len_bits;
		len_bits = 16'(len);
		push_rx(cur_start, 1'b1);
		push_len_byte(len_bits[15:8], esc_pct);
		push_len_byte(len_bits[7:0], esc_pct);
		if (len <= MAX_LEN)
			repeat (len + 1) push_rx(8'($urandom_range(0, 255)), 1'b1);
	endtask

	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(0, 8);
		if (r < 88)
			return $urandom_range(9, 64);
		if (r < 95)
			return $urandom_range(MAX_LEN + 1, 65535);
		return $urandom_range(65, 300);
	endfunction

	// Mostly clean frames, with line noise and headers cut short by a new start byte.
	task automatic push_random_traffic(input int target, input int esc_pct);
		int goal;
		int r;
		logic [7:0] b;
		goal = frame_items_fed + target;
		while (frame_items_fed < goal) begin
			r = $urandom_range(0, 99);
			if (r < 75) begin
				push_frame(pick_len(), esc_pct);
			end else if (r < 87) begin
				repeat ($urandom_range(1, 4)) begin
					b = 8'($urandom_range(0, 255));
					if (b == cur_start)
						b = b + 8'd1;
					push_rx(b, 1'b0);
				end
			end else begin
				push_rx(cur_start, 1'b1);
				if ($urandom_range(0, 1))
					push_rx(cur_escape, 1'b1);
				repeat ($urandom_range(0, 1)) push_rx(8'($urandom_range(0, 255)), 1'b1);
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Default control bytes: start 0x7e, escape 0x7d.
		src_idle_pct = 30;
		sink_idle_pct = 30;
		push_rx(8'h00, 1'b0);
		push_rx(8'hff, 1'b0);
		// Both length bytes escaped, start byte value carried as payload.
		push_rx(8'h7e, 1'b1);
		push_rx(8'h7d, 1'b1);
		push_rx(8'h20, 1'b1);
		push_rx(8'h7d, 1'b1);
		push_rx(8'h22, 1'b1);
		push_rx(8'h7e, 1'b1);
		push_rx(8'h7d, 1'b1);
		push_rx(8'hc3, 1'b1);
		// An escape byte right after an escape byte is the escaped length byte.
		push_rx(8'h7e, 1'b1);
		push_rx(8'h7d, 1'b1);
		push_rx(8'h7d, 1'b1);
		push_rx(8'h00, 1'b1);
		// A start byte after an escape restarts the frame; zero length follows.
		push_rx(8'h7e, 1'b1);
		push_rx(8'h7d, 1'b1);
		push_rx(8'h7e, 1'b1);
		push_rx(8'h00, 1'b1);
		push_rx(8'h00, 1'b1);
		push_rx(8'h5a, 1'b1);
		// Lengths just past the limit and at the top of the range.
		push_rx(8'h7e, 1'b1);
		push_rx(8'h04, 1'b1);
		push_rx(8'h01, 1'b1);
		push_rx(8'h7e, 1'b1);
		push_rx(8'hff, 1'b1);
		push_rx(8'hff, 1'b1);
		push_random_traffic(350, 25);
		wait_idle();

		cfg_write(REG_START_BYTE, 8'h00);
		cfg_write(REG_ESCAPE_BYTE, 8'hff);
		sink_idle_pct = 50;
		push_random_traffic(160, 30);
		wait_idle();

		cfg_write(REG_START_BYTE, 8'hff);
		cfg_write(REG_ESCAPE_BYTE, 8'h00);
		src_idle_pct = 50;
		sink_idle_pct = 10;
		push_random_traffic(160, 30);
		wait_idle();

		// Start and escape share one value, so the start meaning must win.
		cfg_write(REG_START_BYTE, 8'h55);
		cfg_write(REG_ESCAPE_BYTE, 8'h55);
		src_idle_pct = 20;
		sink_idle_pct = 20;
		push_rx(8'h55, 1'b1);
		push_rx(8'h55, 1'b1);
		push_rx(8'h00, 1'b1);
		push_rx(8'h01, 1'b1);
		push_rx(8'h55, 1'b1);
		push_rx(8'h55, 1'b1);
		push_random_traffic(130, 30);
		wait_idle();

		cfg_write(REG_START_BYTE, 8'($urandom_range(0, 255)));
		cfg_write(REG_ESCAPE_BYTE, 8'($urandom_range(0, 255)));
		src_idle_pct = 0;
		sink_idle_pct = 0;
		push_random_traffic(60, 40);
		push_random_traffic(60, 40);
		wait_idle();

		$display("Run covered %0d input items and %0d checked output items.",
			items_accepted, results_checked);
		$display("It closed %0d frames, %0d of them on a rejected length, with 5 settings.",
			frames_closed, length_rejects);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches found", mismatches);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
